>>> sv/ring_buffer_frame_extractor_core_assert.svh
// Assertion macros for the ring buffer frame extractor core.
`ifndef RING_BUFFER_FRAME_EXTRACTOR_CORE_ASSERT_SVH
`define RING_BUFFER_FRAME_EXTRACTOR_CORE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising clock edge outside reset
`define RBFE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbfe same-cycle check failed");
// Next-cycle implication
`define RBFE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbfe next-cycle check failed");
`else
`define RBFE_ASSERT_IMP(label, ante, cons)
`define RBFE_ASSERT_NXT(label, ante, cons)
`endif

`endif

>>> sv/rbfe_pkg.sv
// Shared types and constants for the ring buffer frame extractor.
package rbfe_pkg;

  // Frame header byte, appears twice in a row
  localparam logic [7:0] HDR_BYTE = 8'hA8;

  // Held-byte thresholds and delivery limit
  localparam int HELD_HDR   = 3;
  localparam int HELD_FRAME = 9;
  localparam int MAX_OUT    = 64;

  // Result status codes
  localparam logic [2:0] ST_STORED  = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_OVERRUN = 3'd2;
  localparam logic [2:0] ST_WAIT    = 3'd3;
  localparam logic [2:0] ST_RESYNC  = 3'd4;
  localparam logic [2:0] ST_DATA    = 3'd5;

  // Item opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // Configuration register indexes
  localparam logic CFG_TAIL   = 1'b0;
  localparam logic CFG_MAX_FC = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
    logic       overrun_seen;
  } item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] out_byte;
    logic       last;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BHDR0,
    S_BHDR1,
    S_BCHK,
    S_PHDR1,
    S_PHDR2,
    S_PFUNC,
    S_PLEN,
    S_PTAIL0,
    S_PTAIL1,
    S_PCK,
    S_PSUM,
    S_PERD,
    S_PELD,
    S_RESP
  } state_t;

endpackage

>>> sv/rbfe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rbfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds when re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/ring_buffer_frame_extractor_core.sv
// Ring buffer frame extractor: UART bytes into a ring, framed payload out.
// Byte item: the byte is stored, then the header is checked and a stored result given;
// overrun/full are answered without a store. Poll item: wait/resync answers, resync for
// a bad checksum; a good frame gives its payload bytes in order, one per output transfer,
// each read through the one-read-per-cycle ring port. Output stalls hold delivery; items are taken only in idle.
// Reset (synchronous): indices, entry valid bits and tail marker clear, max_fc to 0xFF; unwritten entries read 0.
`include "ring_buffer_frame_extractor_core_assert.svh"

module ring_buffer_frame_extractor_core #(
  parameter int RING_DEPTH  = 64,
  parameter int FUNC_OFFSET = 2,
  parameter int LEN_OFFSET  = 3,
  parameter int FIXED_LEN   = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  rbfe_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output rbfe_pkg::result_t result,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data
);

  import rbfe_pkg::*;

  localparam int IW = $clog2(RING_DEPTH);
  localparam int TW = $clog2(256 + FIXED_LEN);
  localparam logic [IW:0]   DEPTH_X  = (IW+1)'(RING_DEPTH);
  localparam logic [IW-1:0] ONE_OFF  = IW'(1);
  localparam logic [IW-1:0] PREV_OFF = IW'(RING_DEPTH - 1);
  localparam logic [IW-1:0] FUNC_OFF = IW'(FUNC_OFFSET);
  localparam logic [IW-1:0] LEN_OFF  = IW'(LEN_OFFSET);
  localparam logic [TW-1:0] FIXED_X  = TW'(FIXED_LEN);
  localparam logic [TW-1:0] TOT_MAX  = TW'(RING_DEPTH - 1);
  localparam logic [TW-1:0] TOT_OUT  = TW'(MAX_OUT + 3);
  localparam logic [TW-1:0] TOT_MIN  = TW'(3);

  // Ring position arithmetic, one compare and subtract
  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                             input logic [IW-1:0] off);
    logic [IW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_X) begin
      s = s - DEPTH_X;
    end
    return s[IW-1:0];
  endfunction

  state_t          state, state_next;
  logic [IW-1:0]   rd_idx, rd_idx_next;
  logic [IW-1:0]   wr_idx, wr_idx_next;
  logic [IW-1:0]   idx, idx_next;
  logic [7:0]      sum, sum_next;
  logic [7:0]      b0, b0_next;
  logic [7:0]      ck, ck_next;
  logic [TW-1:0]   tot, tot_next;
  logic            sum_pend, sum_pend_next;
  logic [2:0]      resp_status, resp_status_next;
  logic            result_valid_next;
  result_t         result_next;
  logic [15:0]     tail_marker;
  logic [7:0]      max_fc;
  logic [RING_DEPTH-1:0] ent_valid;
  logic            vld_q;

  logic            mem_we, mem_re;
  logic [IW-1:0]   mem_waddr, mem_raddr;
  logic [7:0]      mem_wdata, mem_rdata;
  logic [7:0]      byte_q;
  logic [IW:0]     held;
  logic [IW-1:0]   tot_i, cnt;
  logic [TW-1:0]   tot_w;
  logic [7:0]      sum_acc;
  logic            out_free;

  rbfe_ram #(
    .WIDTH(8),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Entries never written read as zero
  assign byte_q = vld_q ? mem_rdata : 8'h00;

  // Bytes held in the ring
  always_comb begin
    if (wr_idx >= rd_idx) begin
      held = {1'b0, wr_idx} - {1'b0, rd_idx};
    end else begin
      held = {1'b0, wr_idx} + DEPTH_X - {1'b0, rd_idx};
    end
  end

  assign tot_i    = tot[IW-1:0];
  assign cnt      = tot_i - IW'(3);
  assign tot_w    = TW'(byte_q) + FIXED_X;
  assign sum_acc  = sum_pend ? (sum + byte_q) : sum;
  assign out_free = !result_valid || !result_stall;

  // Sequencer: next state, memory accesses and result loading
  always_comb begin
    state_next        = state;
    rd_idx_next       = rd_idx;
    wr_idx_next       = wr_idx;
    idx_next          = idx;
    sum_next          = sum;
    b0_next           = b0;
    ck_next           = ck;
    tot_next          = tot;
    sum_pend_next     = sum_pend;
    resp_status_next  = resp_status;
    result_valid_next = result_valid && result_stall;
    result_next       = result;
    mem_we            = 1'b0;
    mem_waddr         = wr_idx;
    mem_wdata         = item.rx_byte;
    mem_re            = 1'b0;
    mem_raddr         = rd_idx;
    item_stall        = (state != S_IDLE);

    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          if (item.opcode == OP_BYTE) begin
            if (item.overrun_seen) begin
              resp_status_next = ST_OVERRUN;
              state_next       = S_RESP;
            end else if (wrap_add(wr_idx, ONE_OFF) == rd_idx) begin
              resp_status_next = ST_FULL;
              state_next       = S_RESP;
            end else begin
              mem_we      = 1'b1;
              wr_idx_next = wrap_add(wr_idx, ONE_OFF);
              state_next  = S_BHDR0;
            end
          end else begin
            if (held < (IW+1)'(HELD_HDR)) begin
              resp_status_next = ST_WAIT;
              state_next       = S_RESP;
            end else begin
              mem_re     = 1'b1;
              mem_raddr  = rd_idx;
              state_next = S_PHDR1;
            end
          end
        end
      end

      // Byte path: header check after the store
      S_BHDR0: begin
        mem_re     = 1'b1;
        mem_raddr  = rd_idx;
        state_next = S_BHDR1;
      end
      S_BHDR1: begin
        b0_next    = byte_q;
        mem_re     = 1'b1;
        mem_raddr  = wrap_add(rd_idx, PREV_OFF);
        state_next = S_BCHK;
      end
      S_BCHK: begin
        if (!(b0 == HDR_BYTE && byte_q == HDR_BYTE)) begin
          rd_idx_next = wrap_add(rd_idx, ONE_OFF);
        end
        resp_status_next = ST_STORED;
        state_next       = S_RESP;
      end

      // Poll path
      S_PHDR1: begin
        b0_next    = byte_q;
        mem_re     = 1'b1;
        mem_raddr  = wrap_add(rd_idx, PREV_OFF);
        state_next = S_PHDR2;
      end
      S_PHDR2: begin
        if (!(b0 == HDR_BYTE && byte_q == HDR_BYTE)) begin
          rd_idx_next      = wrap_add(rd_idx, ONE_OFF);
          resp_status_next = ST_RESYNC;
          state_next       = S_RESP;
        end else if (held < (IW+1)'(HELD_FRAME)) begin
          resp_status_next = ST_WAIT;
          state_next       = S_RESP;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = wrap_add(rd_idx, FUNC_OFF);
          state_next = S_PFUNC;
        end
      end
      S_PFUNC: begin
        if (byte_q > max_fc) begin
          rd_idx_next      = wrap_add(rd_idx, ONE_OFF);
          resp_status_next = ST_RESYNC;
          state_next       = S_RESP;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = wrap_add(rd_idx, LEN_OFF);
          state_next = S_PLEN;
        end
      end
      S_PLEN: begin
        tot_next = tot_w;
        if (tot_w > TOT_MAX || tot_w < TOT_MIN || tot_w > TOT_OUT) begin
          rd_idx_next      = wrap_add(rd_idx, ONE_OFF);
          resp_status_next = ST_RESYNC;
          state_next       = S_RESP;
        end else if (TW'(held) < tot_w) begin
          resp_status_next = ST_WAIT;
          state_next       = S_RESP;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = wrap_add(rd_idx, tot_w[IW-1:0] - IW'(2));
          state_next = S_PTAIL0;
        end
      end
      S_PTAIL0: begin
        b0_next    = byte_q;
        mem_re     = 1'b1;
        mem_raddr  = wrap_add(rd_idx, tot_i - ONE_OFF);
        state_next = S_PTAIL1;
      end
      S_PTAIL1: begin
        if ({b0, byte_q} != tail_marker) begin
          rd_idx_next      = wrap_add(rd_idx, ONE_OFF);
          resp_status_next = ST_RESYNC;
          state_next       = S_RESP;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = wrap_add(rd_idx, cnt);
          state_next = S_PCK;
        end
      end
      S_PCK: begin
        ck_next       = byte_q;
        sum_next      = 8'h00;
        idx_next      = ONE_OFF;
        sum_pend_next = 1'b0;
        state_next    = S_PSUM;
      end

      // Checksum walk: one read issued per cycle, its data summed in the next cycle
      S_PSUM: begin
        sum_next = sum_acc;
        if (idx < cnt) begin
          mem_re        = 1'b1;
          mem_raddr     = wrap_add(rd_idx, idx);
          idx_next      = idx + ONE_OFF;
          sum_pend_next = 1'b1;
        end else begin
          sum_pend_next = 1'b0;
          if (!sum_pend) begin
            if (sum == ck) begin
              idx_next   = ONE_OFF;
              state_next = S_PERD;
            end else begin
              rd_idx_next      = wrap_add(rd_idx, ONE_OFF);
              resp_status_next = ST_RESYNC;
              state_next       = S_RESP;
            end
          end
        end
      end

      // Payload delivery, one byte per output transfer
      S_PERD: begin
        mem_re     = 1'b1;
        mem_raddr  = wrap_add(rd_idx, idx);
        state_next = S_PELD;
      end
      S_PELD: begin
        if (out_free) begin
          result_valid_next = 1'b1;
          result_next       = '{status: ST_DATA, out_byte: byte_q, last: (idx == cnt)};
          if (idx == cnt) begin
            rd_idx_next = wrap_add(rd_idx, tot_i);
            state_next  = S_IDLE;
          end else begin
            idx_next   = idx + ONE_OFF;
            state_next = S_PERD;
          end
        end
      end

      // Single-result answer
      S_RESP: begin
        if (out_free) begin
          result_valid_next = 1'b1;
          result_next       = '{status: resp_status, out_byte: 8'h00, last: 1'b1};
          state_next        = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rd_idx       <= '0;
      wr_idx       <= '0;
      sum_pend     <= 1'b0;
      result_valid <= 1'b0;
      ent_valid    <= '0;
    end else begin
      state        <= state_next;
      rd_idx       <= rd_idx_next;
      wr_idx       <= wr_idx_next;
      sum_pend     <= sum_pend_next;
      result_valid <= result_valid_next;
      if (mem_we) begin
        ent_valid[mem_waddr] <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    idx         <= idx_next;
    sum         <= sum_next;
    b0          <= b0_next;
    ck          <= ck_next;
    tot         <= tot_next;
    resp_status <= resp_status_next;
    result      <= result_next;
    if (mem_re) begin
      vld_q <= ent_valid[mem_raddr];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tail_marker <= 16'h0000;
      max_fc      <= 8'hFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TAIL:   tail_marker <= cfg_data;
        CFG_MAX_FC: max_fc      <= cfg_data[7:0];
        default:    ;
      endcase
    end
  end

  // Checks
  `RBFE_ASSERT_IMP(a_store_not_full, state == S_BHDR0, wr_idx != rd_idx)
  `RBFE_ASSERT_IMP(a_pend_in_sum, sum_pend, state == S_PSUM)
  `RBFE_ASSERT_IMP(a_emit_range, state == S_PELD, (idx != '0) && (idx <= cnt))
  `RBFE_ASSERT_NXT(a_emit_last, (state == S_PELD) && out_free && (idx == cnt), (state == S_IDLE) && result_valid && result.last)

endmodule
